### design/pch_pkg.sv
// ----------------------------------------------------------------------------
// pch_pkg - shared types and constants for the pulse channel
// request codes, register indexes, flag bits, lookup tables
// ----------------------------------------------------------------------------
package pch_pkg;

  // request codes
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_TIMER   = 3'd1;
  localparam logic [2:0] REQ_QUARTER = 3'd2;
  localparam logic [2:0] REQ_HALF    = 3'd3;
  localparam logic [2:0] REQ_ENABLE  = 3'd4;

  // channel register indexes
  localparam logic [1:0] REG_CTRL    = 2'd0;
  localparam logic [1:0] REG_SWEEP   = 2'd1;
  localparam logic [1:0] REG_TIMER_LO = 2'd2;
  localparam logic [1:0] REG_TIMER_HI = 2'd3;

  // mode flag bit positions
  localparam int unsigned MF_SWEEP_RELOAD = 0;
  localparam int unsigned MF_SWEEP_ON     = 1;
  localparam int unsigned MF_SWEEP_NEG    = 2;
  localparam int unsigned MF_LEN_ON       = 3;
  localparam int unsigned MF_ENV_ON       = 4;
  localparam int unsigned MF_ENV_LOOP     = 5;
  localparam int unsigned MF_ENV_START    = 6;

  // audible timer period range
  localparam logic [15:0] TIMER_MIN = 16'h0008;
  localparam logic [15:0] TIMER_MAX = 16'h07FF;

  localparam logic [3:0] ENV_FULL = 4'd15;

  // length counter load values
  localparam logic [7:0] LEN_LOAD [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // duty waveforms, bit n is sequencer step n
  localparam logic [7:0] DUTY_WAVE [4] = '{
    8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
  };

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] reg_index;
    logic [7:0] write_data;
  } pch_cmd_t;

  typedef struct packed {
    logic [3:0] level;
    logic       length_nonzero;
  } pch_res_t;

endpackage

### design/pch_req_if.sv
// ----------------------------------------------------------------------------
// pch_req_if - request channel
// valid/ready handshake carrying one channel request
// ----------------------------------------------------------------------------
interface pch_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [1:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, output req_type, output reg_index, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input reg_index, input write_data,
                  output ready);
endinterface

### design/pch_res_if.sv
// ----------------------------------------------------------------------------
// pch_res_if - result channel
// valid/ready handshake carrying the channel level and length flag
// ----------------------------------------------------------------------------
interface pch_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic       length_nonzero;

  modport source (output valid, output level, output length_nonzero, input ready);
  modport sink   (input valid, input level, input length_nonzero, output ready);
endinterface

### design/pch_chan.sv
// ----------------------------------------------------------------------------
// pch_chan - channel state and update logic
// applies one request to the channel state, gives the level after it
// ----------------------------------------------------------------------------
module pch_chan import pch_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  pch_cmd_t cmd,
  input  logic     first_channel,
  output pch_res_t res
);

  logic        enabled_r, enabled_nxt;
  logic [1:0]  duty_mode_r, duty_mode_nxt;
  logic [3:0]  vol_r, vol_nxt;
  logic [6:0]  flags_r, flags_nxt;
  logic [2:0]  sw_shift_r, sw_shift_nxt;
  logic [3:0]  sw_period_r, sw_period_nxt;
  logic [3:0]  sw_count_r, sw_count_nxt;
  logic [15:0] tperiod_r, tperiod_nxt;
  logic [15:0] tcount_r, tcount_nxt;
  logic [2:0]  duty_step_r, duty_step_nxt;
  logic [3:0]  env_vol_r, env_vol_nxt;
  logic [3:0]  env_div_r, env_div_nxt;
  logic [7:0]  len_r, len_nxt;

  logic [15:0] sw_delta;
  logic [15:0] sw_target;
  logic        sw_apply;
  logic [7:0]  wave;

  // sweep target period, modulo 2^16
  always_comb begin
    sw_delta = tperiod_r >> sw_shift_r;
    if (flags_r[MF_SWEEP_NEG]) begin
      sw_target = tperiod_r - sw_delta - {15'd0, first_channel};
    end else begin
      sw_target = tperiod_r + sw_delta;
    end
  end

  always_comb begin
    enabled_nxt   = enabled_r;
    duty_mode_nxt = duty_mode_r;
    vol_nxt       = vol_r;
    flags_nxt     = flags_r;
    sw_shift_nxt  = sw_shift_r;
    sw_period_nxt = sw_period_r;
    sw_count_nxt  = sw_count_r;
    tperiod_nxt   = tperiod_r;
    tcount_nxt    = tcount_r;
    duty_step_nxt = duty_step_r;
    env_vol_nxt   = env_vol_r;
    env_div_nxt   = env_div_r;
    len_nxt       = len_r;
    sw_apply      = 1'b0;

    case (cmd.req_type)
      REQ_WRITE: begin
        case (cmd.reg_index)
          REG_CTRL: begin
            duty_mode_nxt           = cmd.write_data[7:6];
            vol_nxt                 = cmd.write_data[3:0];
            flags_nxt[MF_LEN_ON]    = ~cmd.write_data[5];
            flags_nxt[MF_ENV_LOOP]  = cmd.write_data[5];
            flags_nxt[MF_ENV_ON]    = ~cmd.write_data[4];
            flags_nxt[MF_ENV_START] = 1'b1;
          end
          REG_SWEEP: begin
            sw_shift_nxt               = cmd.write_data[2:0];
            sw_period_nxt              = {1'b0, cmd.write_data[6:4]} + 4'd1;
            flags_nxt[MF_SWEEP_ON]     = cmd.write_data[7];
            flags_nxt[MF_SWEEP_NEG]    = cmd.write_data[3];
            flags_nxt[MF_SWEEP_RELOAD] = 1'b1;
          end
          REG_TIMER_LO: begin
            tperiod_nxt = {tperiod_r[15:8], cmd.write_data};
          end
          default: begin
            len_nxt                 = LEN_LOAD[cmd.write_data[7:3]];
            tperiod_nxt             = {5'd0, cmd.write_data[2:0], tperiod_r[7:0]};
            flags_nxt[MF_ENV_START] = 1'b1;
            duty_step_nxt           = 3'd0;
          end
        endcase
      end
      REQ_TIMER: begin
        if (tcount_r == 16'd0) begin
          tcount_nxt    = tperiod_r;
          duty_step_nxt = duty_step_r + 3'd1;
        end else begin
          tcount_nxt = tcount_r - 16'd1;
        end
      end
      REQ_QUARTER: begin
        if (flags_r[MF_ENV_START]) begin
          env_vol_nxt             = ENV_FULL;
          env_div_nxt             = vol_r;
          flags_nxt[MF_ENV_START] = 1'b0;
        end else if (env_div_r != 4'd0) begin
          env_div_nxt = env_div_r - 4'd1;
        end else begin
          env_div_nxt = vol_r;
          if (env_vol_r != 4'd0) begin
            env_vol_nxt = env_vol_r - 4'd1;
          end else if (flags_r[MF_ENV_LOOP]) begin
            env_vol_nxt = ENV_FULL;
          end
        end
      end
      REQ_HALF: begin
        // length first, then sweep
        if (flags_r[MF_LEN_ON] && len_r != 8'd0) begin
          len_nxt = len_r - 8'd1;
        end
        if (flags_r[MF_SWEEP_RELOAD]) begin
          sw_apply                   = flags_r[MF_SWEEP_ON] && (sw_count_r == 4'd0);
          sw_count_nxt               = sw_period_r;
          flags_nxt[MF_SWEEP_RELOAD] = 1'b0;
        end else if (sw_count_r != 4'd0) begin
          sw_count_nxt = sw_count_r - 4'd1;
        end else begin
          sw_apply     = flags_r[MF_SWEEP_ON];
          sw_count_nxt = sw_period_r;
        end
        if (sw_apply) begin
          tperiod_nxt = sw_target;
        end
      end
      REQ_ENABLE: begin
        enabled_nxt = cmd.write_data[0];
        if (!cmd.write_data[0]) begin
          len_nxt = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // level after this request
  always_comb begin
    wave               = DUTY_WAVE[duty_mode_nxt];
    res.length_nonzero = (len_nxt != 8'd0);
    if (!enabled_nxt || len_nxt == 8'd0 || !wave[duty_step_nxt] ||
        tperiod_nxt < TIMER_MIN || tperiod_nxt > TIMER_MAX) begin
      res.level = 4'd0;
    end else if (flags_nxt[MF_ENV_ON]) begin
      res.level = env_vol_nxt;
    end else begin
      res.level = vol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      duty_mode_r <= '0;
      vol_r       <= '0;
      flags_r     <= '0;
      sw_shift_r  <= '0;
      sw_period_r <= '0;
      sw_count_r  <= '0;
      tperiod_r   <= '0;
      tcount_r    <= '0;
      duty_step_r <= '0;
      env_vol_r   <= '0;
      env_div_r   <= '0;
      len_r       <= '0;
    end else if (step_en) begin
      enabled_r   <= enabled_nxt;
      duty_mode_r <= duty_mode_nxt;
      vol_r       <= vol_nxt;
      flags_r     <= flags_nxt;
      sw_shift_r  <= sw_shift_nxt;
      sw_period_r <= sw_period_nxt;
      sw_count_r  <= sw_count_nxt;
      tperiod_r   <= tperiod_nxt;
      tcount_r    <= tcount_nxt;
      duty_step_r <= duty_step_nxt;
      env_vol_r   <= env_vol_nxt;
      env_div_r   <= env_div_nxt;
      len_r       <= len_nxt;
    end
  end

endmodule

### design/pulse_channel_envelope_sweep_core.sv
// ----------------------------------------------------------------------------
// pulse_channel_envelope_sweep_core - square-wave channel with envelope/sweep
// request register, channel update, result register
// ----------------------------------------------------------------------------
// path: a transferred request is held in the request register, then its result
//   is held in the result register until the result transfer
// throughput: one request per cycle; the request stalls only while a result
//   waits and the request register is also full
// reset: synchronous active-low rst_n clears the channel state and both
//   stage valids; first_channel returns to 1
// ----------------------------------------------------------------------------
module pulse_channel_envelope_sweep_core import pch_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  pch_req_if.sink       in_ch,
  pch_res_if.source     out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  // configuration: one's-complement negate select
  logic first_channel_r;

  // request register stage
  logic     req_valid_r;
  pch_cmd_t req_r;

  // result register stage
  logic     res_valid_r;
  pch_res_t res_r;

  pch_res_t res_nxt;
  logic     step_en;
  logic     in_xfer;

  // request moves on when the result slot is free or being drained
  assign step_en = req_valid_r && (!res_valid_r || out_ch.ready);

  // take a new request whenever the request register is empty or empties this cycle
  assign in_ch.ready = !req_valid_r || step_en;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_channel_r <= 1'b1;
    end else if (cfg_we) begin
      first_channel_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_xfer) begin
      req_valid_r <= 1'b1;
    end else if (step_en) begin
      req_valid_r <= 1'b0;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r.req_type   <= in_ch.req_type;
      req_r.reg_index  <= in_ch.reg_index;
      req_r.write_data <= in_ch.write_data;
    end
  end

  // channel state update and level computed from the updated state
  pch_chan u_chan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .cmd           (req_r),
    .first_channel (first_channel_r),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step_en) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = res_valid_r;
  assign out_ch.level          = res_r.level;
  assign out_ch.length_nonzero = res_r.length_nonzero;

endmodule
